[rtl/cubic_hermite_interp_macros.svh]
// ----------------------------------------------------------------------------
// Cubic Hermite interpolator assertion macros
// Shared concurrent assertion forms used by the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef CUBIC_HERMITE_INTERP_MACROS_SVH
`define CUBIC_HERMITE_INTERP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chi_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic Hermite interpolator package
// Widths, latencies and saturating helpers shared by the interpolator.
// ----------------------------------------------------------------------------
package chi_pkg;

  localparam int DW       = 32;
  localparam int FRAC     = 16;
  localparam int QW       = DW + FRAC;
  localparam int DIV_LAT  = QW;
  localparam int QMUL_LAT = 5;

  typedef logic signed [63:0] q64_t;
  typedef logic signed [31:0] q32_t;

  localparam q64_t Q_ONE   = 64'sd65536;
  localparam q64_t Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q64_t Q64_MIN = 64'sh8000_0000_0000_0000;
  localparam q32_t Q32_MAX = 32'sh7FFF_FFFF;
  localparam q32_t Q32_MIN = 32'sh8000_0000;

  function automatic q64_t sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic q64_t sat_add(q64_t a, q64_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? Q64_MIN : Q64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic q32_t sat32(q64_t v);
    if (v > 64'sd2147483647) begin
      return Q32_MAX;
    end
    if (v < -64'sd2147483648) begin
      return Q32_MIN;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/chi_delay.sv]
// ----------------------------------------------------------------------------
// Enabled delay line
// Shifts a word through DEPTH registers to align it with the datapath.
// ----------------------------------------------------------------------------
module chi_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

[rtl/chi_div.sv]
// ----------------------------------------------------------------------------
// Pipelined fractional divider
// Unsigned (num * 2^FRAC) / den, one restoring step per register stage.
// ----------------------------------------------------------------------------
module chi_div import chi_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [DIV_LAT];
  logic [QW-1:0] aq_q  [DIV_LAT];
  logic [DW-1:0] den_q [DIV_LAT];

  // aq holds the dividend bits still to be consumed on top and the
  // quotient bits produced so far at the bottom.
  for (genvar g = 0; g < DIV_LAT; g++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] aq_in;
    logic [DW:0]   trial;
    logic          take;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign aq_in  = {num, {FRAC{1'b0}}};
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign aq_in  = aq_q[g-1];
      assign den_in = den_q[g-1];
    end

    assign trial = {rem_in, aq_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        aq_q[g]  <= {aq_in[QW-2:0], take};
        den_q[g] <= den_in;
      end
    end
  end

  assign quo = aq_q[DIV_LAT-1];

endmodule

[rtl/chi_qmul.sv]
// ----------------------------------------------------------------------------
// Pipelined Q16.16 multiplier
// 64x64 signed product scaled by 2^-16, rounded half up, saturated to 64 bits.
// ----------------------------------------------------------------------------
module chi_qmul import chi_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q64_t a,
  input  q64_t b,
  output q64_t p
);

  logic          neg1, neg2, neg3, neg4;
  logic [63:0]   ua1, ub1;
  logic [63:0]   p00, p01, p10, p11;
  logic [64:0]   mid3, lo3;
  logic [63:0]   hi3;
  logic [127:0]  prod4;
  logic [111:0]  r4;
  logic          big4;

  assign r4   = prod4[127:16];
  assign big4 = |r4[111:63];

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitudes and result sign.
      neg1 <= a[63] ^ b[63];
      ua1  <= a[63] ? 64'(-a) : a;
      ub1  <= b[63] ? 64'(-b) : b;
      // Four 32x32 partial products.
      neg2 <= neg1;
      p00  <= ua1[31:0]  * ub1[31:0];
      p01  <= ua1[31:0]  * ub1[63:32];
      p10  <= ua1[63:32] * ub1[31:0];
      p11  <= ua1[63:32] * ub1[63:32];
      // Middle sum, and the rounding constant folded into the low word.
      neg3 <= neg2;
      mid3 <= {1'b0, p01} + {1'b0, p10};
      lo3  <= {1'b0, p00} + (neg2 ? 65'h7FFF : 65'h8000);
      hi3  <= p11;
      // Full rounded product.
      neg4  <= neg3;
      prod4 <= {hi3, 64'b0} + {63'b0, lo3} + {31'b0, mid3, 32'b0};
      // Scale, saturate and restore the sign.
      if (big4) begin
        p <= neg4 ? Q64_MIN : Q64_MAX;
      end else begin
        p <= neg4 ? 64'(-r4[63:0]) : r4[63:0];
      end
    end
  end

endmodule

[rtl/cubic_hermite_interp.sv]
// ----------------------------------------------------------------------------
// Cubic Hermite interpolator
// Evaluates one component of a cubic Hermite segment and its slope, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one beat per evaluation: the
// segment end positions, end values, end slopes and the query position, all
// signed Q16.16. The output channel (out_valid/out_ready) returns one beat per
// input beat, in order: the interpolated value, its slope versus position, and
// the zero_span flag, which is set with both results zero when the two end
// positions are equal.
// One beat may be accepted every cycle while the pipeline is not halted. The
// latency is set by the 48-stage divider, which retires one quotient bit per
// stage, and by the 5-stage multipliers.
// The pipeline moves as a whole. It only halts when the output register holds
// a beat the receiver has not taken and the last stage also holds one; then
// in_ready drops and every stage keeps its contents. Bubbles still drain into
// the output side while a result waits.
// A synchronous reset clears all valid bits and the output register's valid;
// the datapath registers are not reset.
// ----------------------------------------------------------------------------
`include "cubic_hermite_interp_macros.svh"

module cubic_hermite_interp import chi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_pos,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] start_slope,
  input  logic signed [31:0] end_pos,
  input  logic signed [31:0] end_value,
  input  logic signed [31:0] end_slope,
  input  logic signed [31:0] query_pos,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_slope,
  output logic               zero_span
);

  // Stage numbers: each names the register stage where a value lands.
  localparam int ST_ABS  = 1;
  localparam int ST_DIV  = ST_ABS + DIV_LAT;
  localparam int ST_SGN  = ST_DIV + 1;
  localparam int ST_T2   = ST_SGN + QMUL_LAT;
  localparam int ST_T3   = ST_T2 + QMUL_LAT;
  localparam int ST_POLY = ST_T3 + 1;
  localparam int ST_PROD = ST_POLY + QMUL_LAT;
  localparam int ST_SUM  = ST_PROD + 1;
  localparam int ST_SPAN = ST_SUM + QMUL_LAT;
  localparam int ST_ACC  = ST_SPAN + 1;

  localparam logic [QW-1:0] T_POS_LIM = {{(QW-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic [QW-1:0] T_NEG_LIM = {{(QW-32){1'b0}}, 32'h8000_0000};

  logic              adv;
  logic [ST_ACC:0]   vld;

  // The whole pipeline steps unless the last stage is blocked by a full,
  // stalled output register.
  assign adv      = !vld[ST_ACC] || !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_ACC-1:0], in_valid};
    end
  end

  // Stage 0: exact 33-bit differences.
  logic signed [32:0] span0, dx0, dp0;
  logic               zero0;
  logic [127:0]       pm0;

  always_ff @(posedge clk) begin
    if (adv) begin
      span0 <= {end_pos[31], end_pos} - {start_pos[31], start_pos};
      dx0   <= {query_pos[31], query_pos} - {start_pos[31], start_pos};
      dp0   <= {end_value[31], end_value} - {start_value[31], start_value};
      zero0 <= (start_pos == end_pos);
      pm0   <= {start_value, end_value, start_slope, end_slope};
    end
  end

  // Stage 1: magnitudes and quotient signs. A 33-bit difference of two
  // 32-bit values never exceeds 2^32-1 in magnitude.
  logic [DW-1:0] smag1, tmag1, qmag1;
  logic [1:0]    sgn1, sgn_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      smag1 <= span0[32] ? DW'(-span0) : span0[DW-1:0];
      tmag1 <= dx0[32] ? DW'(-dx0) : dx0[DW-1:0];
      qmag1 <= dp0[32] ? DW'(-dp0) : dp0[DW-1:0];
      sgn1  <= {dp0[32] ^ span0[32], dx0[32] ^ span0[32]};
    end
  end

  logic [QW-1:0] qt, qq;

  chi_div u_div_t (.clk(clk), .en(adv), .num(tmag1), .den(smag1), .quo(qt));
  chi_div u_div_q (.clk(clk), .en(adv), .num(qmag1), .den(smag1), .quo(qq));

  chi_delay #(.W(2), .DEPTH(DIV_LAT)) u_dly_sgn (
    .clk(clk), .en(adv), .d(sgn1), .q(sgn_d)
  );

  // Signed t, saturated to Q16.16, and the unsaturated value-difference
  // quotient.
  q32_t               t_s;
  logic signed [QW:0] q_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!sgn_d[0]) begin
        t_s <= (qt > T_POS_LIM) ? Q32_MAX : qt[31:0];
      end else begin
        t_s <= (qt > T_NEG_LIM) ? Q32_MIN : -qt[31:0];
      end
      q_s <= sgn_d[1] ? -{1'b0, qq} : {1'b0, qq};
    end
  end

  // Powers of t.
  q64_t t2, t3, t2_d;
  q32_t t_d5, t_d10;

  chi_qmul u_mul_t2 (.clk(clk), .en(adv), .a(sx32(t_s)), .b(sx32(t_s)), .p(t2));

  chi_delay #(.W(32), .DEPTH(ST_T2 - ST_SGN)) u_dly_t5 (
    .clk(clk), .en(adv), .d(t_s), .q(t_d5)
  );

  chi_qmul u_mul_t3 (.clk(clk), .en(adv), .a(t2), .b(sx32(t_d5)), .p(t3));

  chi_delay #(.W(32), .DEPTH(ST_T3 - ST_SGN)) u_dly_t10 (
    .clk(clk), .en(adv), .d(t_s), .q(t_d10)
  );

  chi_delay #(.W(64), .DEPTH(ST_T3 - ST_T2)) u_dly_t2 (
    .clk(clk), .en(adv), .d(t2), .q(t2_d)
  );

  // Basis polynomials and their derivatives. Every term fits in 64 bits,
  // so plain wrapping arithmetic is exact here.
  q64_t tt;
  q64_t h00, h10, h01, h11, g01, g10, g11;

  assign tt = sx32(t_d10);

  always_ff @(posedge clk) begin
    if (adv) begin
      h00 <= Q_ONE - ((t2_d <<< 1) + t2_d) + (t3 <<< 1);
      h10 <= tt - (t2_d <<< 1) + t3;
      h01 <= ((t2_d <<< 1) + t2_d) - (t3 <<< 1);
      h11 <= t3 - t2_d;
      g01 <= ((tt <<< 2) + (tt <<< 1)) - ((t2_d <<< 2) + (t2_d <<< 1));
      g10 <= Q_ONE - (tt <<< 2) + ((t2_d <<< 1) + t2_d);
      g11 <= ((t2_d <<< 1) + t2_d) - (tt <<< 1);
    end
  end

  // Endpoint data and quotient aligned with the basis stage.
  logic [127:0]       pm_d;
  logic signed [QW:0] q_d;
  q64_t               p0e, p1e, m0e, m1e, qe;

  chi_delay #(.W(128), .DEPTH(ST_POLY)) u_dly_pm (
    .clk(clk), .en(adv), .d(pm0), .q(pm_d)
  );

  chi_delay #(.W(QW + 1), .DEPTH(ST_POLY - ST_SGN)) u_dly_q (
    .clk(clk), .en(adv), .d(q_s), .q(q_d)
  );

  assign p0e = sx32(pm_d[127:96]);
  assign p1e = sx32(pm_d[95:64]);
  assign m0e = sx32(pm_d[63:32]);
  assign m1e = sx32(pm_d[31:0]);
  assign qe  = {{(63 - QW){q_d[QW]}}, q_d};

  // Seven weighted terms in parallel.
  q64_t a1, a2, a3, a4, b1, b2, b3;

  chi_qmul u_mul_a1 (.clk(clk), .en(adv), .a(h10), .b(m0e), .p(a1));
  chi_qmul u_mul_a2 (.clk(clk), .en(adv), .a(h11), .b(m1e), .p(a2));
  chi_qmul u_mul_a3 (.clk(clk), .en(adv), .a(h00), .b(p0e), .p(a3));
  chi_qmul u_mul_a4 (.clk(clk), .en(adv), .a(h01), .b(p1e), .p(a4));
  chi_qmul u_mul_b1 (.clk(clk), .en(adv), .a(g01), .b(qe),  .p(b1));
  chi_qmul u_mul_b2 (.clk(clk), .en(adv), .a(g10), .b(m0e), .p(b2));
  chi_qmul u_mul_b3 (.clk(clk), .en(adv), .a(g11), .b(m1e), .p(b3));

  // First saturating sums.
  q64_t s_sum, slp1, a3_s, a4_s, b3_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s_sum <= sat_add(a1, a2);
      slp1  <= sat_add(b1, b2);
      a3_s  <= a3;
      a4_s  <= a4;
      b3_s  <= b3;
    end
  end

  // The slope terms of the value are scaled back to value units by the span.
  logic signed [32:0] span_d;
  q64_t               vspan;
  logic [255:0]       acc_d;
  q64_t               slp1_d, a3_d, a4_d, b3_d;

  chi_delay #(.W(33), .DEPTH(ST_SUM)) u_dly_span (
    .clk(clk), .en(adv), .d(span0), .q(span_d)
  );

  chi_qmul u_mul_span (
    .clk(clk), .en(adv), .a({{31{span_d[32]}}, span_d}), .b(s_sum), .p(vspan)
  );

  chi_delay #(.W(256), .DEPTH(ST_SPAN - ST_SUM)) u_dly_acc (
    .clk(clk), .en(adv), .d({slp1, a3_s, a4_s, b3_s}), .q(acc_d)
  );

  assign slp1_d = acc_d[255:192];
  assign a3_d   = acc_d[191:128];
  assign a4_d   = acc_d[127:64];
  assign b3_d   = acc_d[63:0];

  q64_t val1, slp2, a4_acc;

  always_ff @(posedge clk) begin
    if (adv) begin
      val1   <= sat_add(vspan, a3_d);
      slp2   <= sat_add(slp1_d, b3_d);
      a4_acc <= a4_d;
    end
  end

  logic zero_d;

  chi_delay #(.W(1), .DEPTH(ST_ACC)) u_dly_zero (
    .clk(clk), .en(adv), .d(zero0), .q(zero_d)
  );

  // Output register: takes the last stage whenever it is empty or drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= vld[ST_ACC];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_value <= zero_d ? '0 : sat32(sat_add(val1, a4_acc));
      out_slope <= zero_d ? '0 : sat32(slp2);
      zero_span <= zero_d;
    end
  end

  `CHI_ASSERT_NOW(a_zero_out, clk, rst, out_valid && zero_span, out_value == '0 && out_slope == '0, "zero span beat carries nonzero results")
  `CHI_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready && vld[ST_ACC], "pipeline halted without a blocked output")
  `CHI_ASSERT_NEXT(a_drain, clk, rst, vld[ST_ACC] && (!out_valid || out_ready), out_valid, "last stage beat lost on its way out")
  `CHI_ASSERT_NEXT(a_hold, clk, rst, !in_ready, $stable(vld), "valid bits moved during a halt")

endmodule

[tb/tb_cubic_hermite_interp.sv]
// ----------------------------------------------------------------------------
// Cubic Hermite interpolator testbench
// Drives directed and random spline segments into the interpolator, predicts
// each interpolated value, slope and zero-span flag in Q16.16 unless a directed
// row types it in, and checks every output beat in order against the expectation.
// ----------------------------------------------------------------------------
module tb_cubic_hermite_interp import chi_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One input beat: a segment component plus the query abscissa.
  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_value;
    logic signed [31:0] start_slope;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_value;
    logic signed [31:0] end_slope;
    logic signed [31:0] query_pos;
  } segment_t;

  // One output beat.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic               zero_span;
  } curve_point_t;

  // A directed row: the expected point is typed in only when it is obvious.
  typedef struct packed {
    segment_t     seg;
    logic         known;
    curve_point_t point;
  } directed_row_t;

  localparam int N_RANDOM    = 1800;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 120;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q   = 32'sh0001_0000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] start_pos;
  logic signed [31:0] start_value;
  logic signed [31:0] start_slope;
  logic signed [31:0] end_pos;
  logic signed [31:0] end_value;
  logic signed [31:0] end_slope;
  logic signed [31:0] query_pos;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value;
  logic signed [31:0] out_slope;
  logic               zero_span;

  curve_point_t pending_points[$];
  int           error_count;
  int           idle_cycles;

  cubic_hermite_interp u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_pos   (start_pos),
    .start_value (start_value),
    .start_slope (start_slope),
    .end_pos     (end_pos),
    .end_value   (end_value),
    .end_slope   (end_slope),
    .query_pos   (query_pos),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_slope   (out_slope),
    .zero_span   (zero_span)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Fixed-point arithmetic of the predictor.
  // --------------------------------------------------------------------------

  function automatic logic [63:0] magnitude(q64_t a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic q64_t add_sat64(q64_t a, q64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return Q64_MIN;
    return s[63:0];
  endfunction

  // Product of two Q16.16 numbers: round half toward plus infinity on the
  // magnitude side (0x8000 up, 0x7FFF for negative), then clamp to 64 bits.
  function automatic q64_t mul_q16(q64_t a, q64_t b);
    logic         neg;
    logic [127:0] prod;
    logic [127:0] scaled;
    neg = a[63] ^ b[63];
    prod = 128'(magnitude(a)) * 128'(magnitude(b));
    prod = prod + (neg ? 128'h7FFF : 128'h8000);
    scaled = prod >> 16;
    if (neg) begin
      if (scaled >= (128'd1 << 63)) return Q64_MIN;
      return -q64_t'(scaled[63:0]);
    end
    if (scaled > 128'h7FFF_FFFF_FFFF_FFFF) return Q64_MAX;
    return q64_t'(scaled[63:0]);
  endfunction

  // Quotient (num << 16) / den, truncated toward zero.
  function automatic q64_t div_q16(q64_t num, q64_t den);
    logic [63:0] q;
    q = (magnitude(num) << 16) / magnitude(den);
    return (num[63] != den[63]) ? -q64_t'(q) : q64_t'(q);
  endfunction

  function automatic q64_t clamp32(q64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic q64_t ext32(logic signed [31:0] v);
    return q64_t'(v);
  endfunction

  // Evaluates the Hermite interpolant and its derivative for one segment.
  function automatic curve_point_t hermite_eval(segment_t seg);
    curve_point_t pt;
    q64_t x0, p0, m0, x1, p1, m1, x, span;
    q64_t t, t2, t3, h00, h10, h01, h11, g01, g10, g11, chord, val, slp;
    x0 = ext32(seg.start_pos);
    p0 = ext32(seg.start_value);
    m0 = ext32(seg.start_slope);
    x1 = ext32(seg.end_pos);
    p1 = ext32(seg.end_value);
    m1 = ext32(seg.end_slope);
    x  = ext32(seg.query_pos);
    span = x1 - x0;
    pt = '0;
    if (span == 0) begin
      pt.zero_span = 1'b1;
      return pt;
    end
    t   = clamp32(div_q16(x - x0, span));
    t2  = mul_q16(t, t);
    t3  = mul_q16(t2, t);
    h00 = Q_ONE - 3 * t2 + 2 * t3;
    h10 = t - 2 * t2 + t3;
    h01 = 3 * t2 - 2 * t3;
    h11 = t3 - t2;
    g01 = 6 * t - 6 * t2;
    g10 = Q_ONE - 4 * t + 3 * t2;
    g11 = 3 * t2 - 2 * t;
    val = mul_q16(span, add_sat64(mul_q16(h10, m0), mul_q16(h11, m1)));
    val = add_sat64(val, mul_q16(h00, p0));
    val = add_sat64(val, mul_q16(h01, p1));
    chord = div_q16(p1 - p0, span);
    slp = mul_q16(g01, chord);
    slp = add_sat64(slp, mul_q16(g10, m0));
    slp = add_sat64(slp, mul_q16(g11, m1));
    pt.value = 32'(clamp32(val));
    pt.slope = 32'(clamp32(slp));
    return pt;
  endfunction

  // --------------------------------------------------------------------------
  // Random segments. Most are well-formed: a modest span with the query near
  // the segment so that t stays in a useful range. The rest are raw 32-bit
  // noise, which exercises saturation, and zero-span segments.
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'($urandom_range(0, 65535)) - 32'sd32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    logic signed [31:0] span;
    int unsigned        kind;
    kind = $urandom_range(0, 99);
    s.start_value = rand_word();
    s.start_slope = rand_word();
    s.end_value   = rand_word();
    s.end_slope   = rand_word();
    if (kind < 70) begin
      // A moderate segment with moderate values so the curve stays in range.
      s.start_pos   = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      span          = 32'($urandom_range(1, 32'h0010_0000));
      if ($urandom_range(0, 1)) span = -span;
      s.end_pos     = s.start_pos + span;
      s.query_pos   = s.start_pos
                      + 32'(($signed(64'(span)) * $signed(64'($urandom_range(0, 1536))
                      - 64'sd256)) / 64'sd1024);
      s.start_value = $signed(s.start_value) >>> $urandom_range(0, 12);
      s.end_value   = $signed(s.end_value) >>> $urandom_range(0, 12);
      s.start_slope = $signed(s.start_slope) >>> $urandom_range(0, 12);
      s.end_slope   = $signed(s.end_slope) >>> $urandom_range(0, 12);
    end else if (kind < 76) begin
      s.start_pos = rand_word();
      s.end_pos   = s.start_pos;
      s.query_pos = rand_word();
    end else begin
      s.start_pos = rand_word();
      s.end_pos   = rand_word();
      s.query_pos = rand_word();
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Directed rows: zero span, query at the start (value and slope are the
  // start values), query at the end, extrapolation and extreme fields.
  // --------------------------------------------------------------------------
  directed_row_t directed_rows[$];

  function automatic segment_t make_seg(logic signed [31:0] x0, logic signed [31:0] p0,
                                        logic signed [31:0] m0, logic signed [31:0] x1,
                                        logic signed [31:0] p1, logic signed [31:0] m1,
                                        logic signed [31:0] x);
    segment_t s;
    s = '{x0, p0, m0, x1, p1, m1, x};
    return s;
  endfunction

  task automatic add_row(segment_t seg, logic known, curve_point_t pt);
    directed_row_t row;
    row.seg   = seg;
    row.known = known;
    row.point = pt;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    curve_point_t none;
    none = '0;
    // Zero span gives zeros and the flag, whatever the rest holds.
    add_row(make_seg(0, 0, 0, 0, 0, 0, 0), 1'b1, '{32'sd0, 32'sd0, 1'b1});
    add_row(make_seg(S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN),
            1'b1, '{32'sd0, 32'sd0, 1'b1});
    add_row(make_seg(S32_MIN, -1, -1, S32_MIN, -1, -1, -1), 1'b1, '{32'sd0, 32'sd0, 1'b1});
    // Query at the start: t is zero, so the start value and slope come back.
    add_row(make_seg(0, 32'sh0003_0000, 32'sh0000_8000, ONE_Q, 32'sh0005_0000, 0, 0),
            1'b1, '{32'sh0003_0000, 32'sh0000_8000, 1'b0});
    add_row(make_seg(S32_MIN, S32_MAX, S32_MIN, S32_MAX, 0, 0, S32_MIN),
            1'b1, '{S32_MAX, S32_MIN, 1'b0});
    add_row(make_seg(-5, -7, 123, 9, 11, 13, -5), 1'b1, '{-32'sd7, 32'sd123, 1'b0});
    // Query at the end, at the midpoint, and well outside the segment.
    add_row(make_seg(0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q), 1'b0, none);
    add_row(make_seg(0, 0, 0, 32'sh0002_0000, 32'sh0004_0000, 0, ONE_Q), 1'b0, none);
    add_row(make_seg(ONE_Q, ONE_Q, -ONE_Q, 32'sh0002_0000, 0, ONE_Q, 32'sh0010_0000),
            1'b0, none);
    add_row(make_seg(0, ONE_Q, ONE_Q, ONE_Q, 0, 0, -32'sh0020_0000), 1'b0, none);
    // Reversed segment, span of one LSB, and the widest spans.
    add_row(make_seg(32'sh0004_0000, 0, ONE_Q, 0, ONE_Q, 0, ONE_Q), 1'b0, none);
    add_row(make_seg(0, 0, S32_MAX, 1, S32_MAX, S32_MIN, S32_MAX), 1'b0, none);
    add_row(make_seg(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 0), 1'b0, none);
    add_row(make_seg(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MAX),
            1'b0, none);
    add_row(make_seg(S32_MAX, -1, -1, S32_MIN, -1, -1, S32_MIN), 1'b0, none);
    add_row(make_seg(-1, S32_MAX, S32_MAX, 0, S32_MIN, S32_MIN, S32_MAX), 1'b0, none);
    add_row(make_seg(0, S32_MIN, S32_MAX, -1, S32_MAX, S32_MIN, 32'sh5555_5555), 1'b0, none);
    add_row(make_seg(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_0000), 1'b0, none);
  endtask

  // --------------------------------------------------------------------------
  // Sender. Beats go out in bursts of random length separated by random gaps.
  // The expected point is queued on the edge that accepts the beat; the
  // result must pass the whole pipeline first, so it cannot race it.
  // --------------------------------------------------------------------------
  int burst_left;

  task automatic send_segment(segment_t seg, logic known, curve_point_t typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    start_pos   <= seg.start_pos;
    start_value <= seg.start_value;
    start_slope <= seg.start_slope;
    end_pos     <= seg.end_pos;
    end_value   <= seg.end_value;
    end_slope   <= seg.end_slope;
    query_pos   <= seg.query_pos;
    do @(posedge clk); while (!in_ready);
    pending_points.push_back(known ? typed : hermite_eval(seg));
  endtask

  // Holds the sender back until every expected point has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_valid    <= 1'b0;
    start_pos   <= '0;
    start_value <= '0;
    start_slope <= '0;
    end_pos     <= '0;
    end_value   <= '0;
    end_slope   <= '0;
    query_pos   <= '0;
    rst         <= 1'b1;
    burst_left  = 0;
    build_directed();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_segment(directed_rows[i].seg, directed_rows[i].known, directed_rows[i].point);
    end
    wait_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      send_segment(rand_segment(), 1'b0, '0);
      if (n == N_RANDOM / 2) wait_drained();
    end
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("cubic_hermite_interp: match");
    end else begin
      $display("cubic_hermite_interp: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. The stall pattern changes at random between always ready,
  // random stalls, and long stalls, so back-pressure lands on every phase
  // of the pipeline.
  // --------------------------------------------------------------------------
  int          ready_phase_left;
  int unsigned ready_mode;

  initial begin
    out_ready        <= 1'b0;
    ready_phase_left = 0;
    ready_mode       = 0;
  end

  always @(posedge clk) begin
    if (ready_phase_left == 0) begin
      ready_phase_left = $urandom_range(50, 400);
      ready_mode       = $urandom_range(0, 2);
    end
    ready_phase_left--;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Output checker: each beat is compared field by field with the oldest
  // expected point.
  // --------------------------------------------------------------------------
  initial error_count = 0;

  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: output beat with nothing expected: value %h slope %h flag %b",
                 $time, out_value, out_slope, zero_span);
        error_count++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_value !== exp_pt.value) begin
          $display("%0t: out_value expected %h actual %h", $time, exp_pt.value, out_value);
          error_count++;
        end
        if (out_slope !== exp_pt.slope) begin
          $display("%0t: out_slope expected %h actual %h", $time, exp_pt.slope, out_slope);
          error_count++;
        end
        if (zero_span !== exp_pt.zero_span) begin
          $display("%0t: zero_span expected %b actual %b", $time, exp_pt.zero_span,
                   zero_span);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles with no beat on either channel ends the run.
  // --------------------------------------------------------------------------
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("cubic_hermite_interp: mismatch");
        $finish;
      end
    end
  end

endmodule

[files.f]
+incdir+rtl
rtl/chi_pkg.sv
rtl/chi_delay.sv
rtl/chi_div.sv
rtl/chi_qmul.sv
rtl/cubic_hermite_interp.sv
tb/tb_cubic_hermite_interp.sv
